// ----- design/isq_pkg.sv -----
// isq_pkg: sizes, operation codes and status codes of the indexed sequence store
// used by the store top level and its port checker; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isq_pkg;

  localparam int DEPTH      = 256;
  localparam int ENTRY_BITS = 64;
  localparam int ADDR_W     = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);

  localparam logic [2:0] K_APPEND     = 3'd0;
  localparam logic [2:0] K_POP_FRONT  = 3'd1;
  localparam logic [2:0] K_POP_BACK   = 3'd2;
  localparam logic [2:0] K_REMOVE_AT  = 3'd3;
  localparam logic [2:0] K_READ_AT    = 3'd4;

  localparam logic [1:0] ST_DONE      = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

endpackage

`default_nettype wire

// ----- design/indexed_sequence_store.sv -----
// indexed_sequence_store: ordered sequence of up to DEPTH entry words kept in one
// synchronous memory, with append, front/back/positional removal and positional read
// depends on isq_pkg
//
// usage:
//   input channel in_valid/in_ready carries kind, position and entry_value;
//   output channel out_valid/out_ready carries status, read_value, entry_count,
//   exactly one result per request, in request order
// result path:
//   append, remove back, error cases and unknown kinds go from S_IDLE to S_HOLD and
//   then into the output register; read at a position first passes S_READ (one memory
//   read); removal that closes a gap, front removal of more than one entry included,
//   passes S_SHIFT; the gap is closed by moving one entry per cycle through the
//   memory, read port and write port overlapped; at worst all entries but one are moved
//   one request is worked on at a time; a new request is taken as soon as the
//   previous one has produced its result into the output register
// reset: entry count goes to zero and the output register empties; memory contents
//   are not cleared and no clearing pass is needed
// receiver stall: the result stays in the output register; a finished next result
//   waits internally and no further request is taken until the output frees up
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [2:0]         kind,
  input  wire logic signed [15:0] position,
  input  wire logic [63:0]        entry_value,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              status,
  output logic [63:0]             read_value,
  output logic [8:0]              entry_count
);
  import isq_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_SHIFT, S_READ, S_HOLD} state_t;

  state_t                  state;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        src;
  logic [ADDR_W-1:0]       wr_ptr;
  logic                    pend;
  logic [1:0]              res_status;
  logic [63:0]             res_value;

  logic [ENTRY_BITS-1:0]   mem [DEPTH];
  logic [ENTRY_BITS-1:0]   rd_data;
  logic                    we;
  logic [ADDR_W-1:0]       wa;
  logic [ENTRY_BITS-1:0]   wd;
  logic                    re;
  logic [ADDR_W-1:0]       ra;

  logic                    acc;
  logic                    pos_neg;
  logic [16:0]             pos_ext;
  logic [16:0]             cnt_ext;
  logic                    pos_past;
  logic                    pos_zero;
  logic [ADDR_W-1:0]       drop_s;
  logic                    drop_tail;
  logic                    src_live;
  logic                    out_free;

  assign in_ready = (state == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign pos_neg  = position[15];
  assign pos_ext  = {2'b00, position[14:0]};
  assign cnt_ext  = 17'(count);
  assign pos_past = !pos_neg && (pos_ext >= cnt_ext);
  assign pos_zero = (position == 16'sd0);
  assign drop_s   = (kind == K_REMOVE_AT && !pos_neg && !pos_zero)
                    ? position[ADDR_W-1:0] : '0;
  assign drop_tail = (CNT_W'(drop_s) + CNT_W'(1)) >= count;
  assign src_live = src < count;
  assign out_free = !out_valid || out_ready;

  // memory port control
  always_comb begin
    we = 1'b0;
    wa = count[ADDR_W-1:0];
    wd = entry_value[ENTRY_BITS-1:0];
    re = 1'b0;
    ra = position[ADDR_W-1:0];
    case (state)
      S_IDLE: begin
        if (acc && kind == K_APPEND && count < CNT_W'(DEPTH)) begin
          we = 1'b1;
        end
        if (acc && kind == K_READ_AT && count != '0 && !pos_neg && !pos_past) begin
          re = 1'b1;
        end
      end
      S_SHIFT: begin
        we = pend;
        wa = wr_ptr;
        wd = rd_data;
        re = src_live;
        ra = src[ADDR_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd_data <= mem[ra];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_HOLD) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc) begin
            res_value <= '0;
            case (kind)
              K_APPEND: begin
                state <= S_HOLD;
                if (count >= CNT_W'(DEPTH)) begin
                  res_status <= ST_FULL;
                end else begin
                  res_status <= ST_DONE;
                  count      <= count + CNT_W'(1);
                end
              end
              K_POP_FRONT, K_POP_BACK, K_REMOVE_AT, K_READ_AT: begin
                if (count == '0) begin
                  res_status <= ST_EMPTY;
                  state      <= S_HOLD;
                end else if (kind == K_READ_AT) begin
                  if (pos_neg || pos_past) begin
                    res_status <= ST_NOT_FOUND;
                    state      <= S_HOLD;
                  end else begin
                    res_status <= ST_DONE;
                    state      <= S_READ;
                  end
                end else if (kind == K_POP_BACK || (kind == K_REMOVE_AT && pos_past)
                             || drop_tail) begin
                  res_status <= ST_DONE;
                  count      <= count - CNT_W'(1);
                  state      <= S_HOLD;
                end else begin
                  res_status <= ST_DONE;
                  src        <= CNT_W'(drop_s) + CNT_W'(1);
                  wr_ptr     <= drop_s;
                  pend       <= 1'b0;
                  state      <= S_SHIFT;
                end
              end
              default: begin
                res_status <= ST_DONE;
                state      <= S_HOLD;
              end
            endcase
          end
        end
        S_SHIFT: begin
          if (pend) begin
            wr_ptr <= wr_ptr + ADDR_W'(1);
          end
          if (src_live) begin
            src  <= src + CNT_W'(1);
            pend <= 1'b1;
          end else begin
            pend <= 1'b0;
            if (!pend) begin
              count <= count - CNT_W'(1);
              state <= S_HOLD;
            end
          end
        end
        S_READ: begin
          res_value <= 64'(rd_data);
          state     <= S_HOLD;
        end
        S_HOLD: begin
          if (out_free) begin
            out_valid   <= 1'b1;
            status      <= res_status;
            read_value  <= res_value;
            entry_count <= 9'(count);
            state       <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- design/isq_port_checker.sv -----
// isq_port_checker: port-level assertions for indexed_sequence_store, bound to it
// depends on isq_pkg and indexed_sequence_store
`timescale 1ns / 1ps
`default_nettype none

module isq_port_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [1:0]  status,
  input wire logic [63:0] read_value,
  input wire logic [8:0]  entry_count
);
  import isq_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(read_value)
      && $stable(entry_count))
    else $error("result changed while stalled");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_FULL |-> entry_count == 9'(DEPTH))
    else $error("full reported below capacity");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == ST_EMPTY |-> entry_count == 9'd0)
    else $error("empty reported with entries held");

  a_err_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_DONE |-> read_value == 64'd0)
    else $error("nonzero read value on error");

  a_reset_out: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind indexed_sequence_store isq_port_checker u_isq_port_checker (
  .clk(clk),
  .rst(rst),
  .out_valid(out_valid),
  .out_ready(out_ready),
  .status(status),
  .read_value(read_value),
  .entry_count(entry_count)
);

`default_nettype wire

// ----- test/tb_top.sv -----
// tb_top: self-checking bench for indexed_sequence_store with a queue-based predictor,
// directed edge cases, random operation mixes, random idling and a long output stall
// depends on isq_pkg and indexed_sequence_store
`timescale 1ns / 1ps

module tb_top;
  import isq_pkg::*;

  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int HOLD_CYCLES = 400;

  localparam logic [2:0] K_SPARE_5 = 3'd5;
  localparam logic [2:0] K_SPARE_6 = 3'd6;
  localparam logic [2:0] K_SPARE_7 = 3'd7;

  typedef struct packed {
    logic [1:0]  status;
    logic [63:0] read_value;
    logic [8:0]  entry_count;
  } store_outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [2:0] kind = K_APPEND;
  logic signed [15:0] position = '0;
  logic [63:0] entry_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [63:0] read_value;
  logic [8:0] entry_count;

  logic [ENTRY_BITS-1:0] stored_words[$];
  store_outcome_t awaited_outcomes[$];
  int mismatch_count = 0;
  int burst_left = 0;
  int cycle_count = 0;

  logic hold_active = 1'b0;
  event long_hold_req;
  int mode_left = 0;
  logic [7:0] ready_mask = 8'hFF;
  logic [2:0] mask_phase = '0;

  indexed_sequence_store i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .position   (position),
    .entry_value(entry_value),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .read_value (read_value),
    .entry_count(entry_count)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic store_outcome_t store_op_outcome(input logic [2:0] k,
                                                      input logic signed [15:0] p,
                                                      input logic [63:0] v);
    store_outcome_t r;
    int n;
    r.status = ST_DONE;
    r.read_value = '0;
    n = stored_words.size();
    case (k)
      K_APPEND: begin
        if (n >= DEPTH) r.status = ST_FULL;
        else stored_words.push_back(v[ENTRY_BITS-1:0]);
      end
      K_POP_FRONT, K_POP_BACK, K_REMOVE_AT, K_READ_AT: begin
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else if (k == K_POP_FRONT) begin
          stored_words.delete(0);
        end else if (k == K_POP_BACK) begin
          stored_words.delete(n - 1);
        end else if (k == K_REMOVE_AT) begin
          if (p >= n) stored_words.delete(n - 1);
          else if (p <= 0) stored_words.delete(0);
          else stored_words.delete(p);
        end else if (p < 0 || p >= n) begin
          r.status = ST_NOT_FOUND;
        end else begin
          r.read_value = 64'(stored_words[p]);
        end
      end
      default: ;
    endcase
    r.entry_count = 9'(stored_words.size());
    return r;
  endfunction

  function automatic logic [63:0] rand_word();
    case ($urandom_range(7, 0))
      0: return '0;
      1: return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic signed [15:0] pick_position();
    int n;
    n = stored_words.size();
    case ($urandom_range(9, 0))
      0: return 16'($urandom);
      1: return '0;
      2: return 16'(n - 1);
      default: return 16'($urandom_range(n + 1, 0) - 1);
    endcase
  endfunction

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t ns: %s mismatch, got %0h expected %0h", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic send_request(input logic [2:0] k, input logic signed [15:0] p,
                              input logic [63:0] v);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(6, 1)) @(posedge clk);
      burst_left = ($urandom_range(3, 0) == 0) ? $urandom_range(60, 20) : $urandom_range(8, 1);
    end
    in_valid <= 1'b1;
    kind <= k;
    position <= p;
    entry_value <= v;
    do @(posedge clk); while (!in_ready);
    awaited_outcomes.push_back(store_op_outcome(k, p, v));
    burst_left--;
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    burst_left = 0;
    while (awaited_outcomes.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_empty_store();
    send_request(K_POP_FRONT, '0, '0);
    send_request(K_POP_BACK, 16'sh7FFF, '1);
    send_request(K_REMOVE_AT, '0, '0);
    send_request(K_READ_AT, '0, '0);
    send_request(K_READ_AT, 16'sh8000, '0);
    send_request(K_SPARE_7, 16'sh8000, '1);
    wait_for_results();
  endtask

  task automatic test_single_entry();
    send_request(K_APPEND, '0, '0);
    send_request(K_POP_BACK, '0, '0);
    send_request(K_APPEND, 16'shFFFF, '1);
    send_request(K_READ_AT, '0, '0);
    send_request(K_REMOVE_AT, '0, '0);
    send_request(K_APPEND, '0, 64'h1);
    send_request(K_REMOVE_AT, 16'sh8000, '0);
    send_request(K_APPEND, '0, 64'h2);
    send_request(K_REMOVE_AT, 16'sh7FFF, '0);
    wait_for_results();
  endtask

  task automatic test_positions();
    send_request(K_APPEND, '0, 64'h8000_0000_0000_0000);
    send_request(K_APPEND, '0, 64'h5555_5555_5555_5555);
    send_request(K_APPEND, '0, 64'hAAAA_AAAA_AAAA_AAAA);
    send_request(K_READ_AT, 16'sd2, '0);
    send_request(K_READ_AT, 16'sd3, '0);
    send_request(K_READ_AT, 16'shFFFF, '0);
    send_request(K_REMOVE_AT, 16'sd1, '0);
    send_request(K_READ_AT, 16'sd1, '0);
    send_request(K_POP_FRONT, '0, '0);
    send_request(K_SPARE_5, 16'sh7FFF, '1);
    send_request(K_SPARE_6, '0, '0);
    wait_for_results();
  endtask

  task automatic test_full_store();
    while (stored_words.size() < DEPTH) send_request(K_APPEND, pick_position(), rand_word());
    send_request(K_APPEND, 16'sh7FFF, '1);
    send_request(K_READ_AT, 16'(DEPTH - 1), '0);
    send_request(K_READ_AT, 16'(DEPTH), '0);
    send_request(K_REMOVE_AT, 16'sh7FFF, '0);
    send_request(K_APPEND, '0, rand_word());
    send_request(K_APPEND, '0, rand_word());
    send_request(K_REMOVE_AT, 16'(DEPTH / 2), '0);
    send_request(K_READ_AT, 16'(DEPTH / 2), '0);
    send_request(K_POP_FRONT, '0, '0);
    send_request(K_READ_AT, '0, '0);
    wait_for_results();
  endtask

  task automatic test_random_mix(input int n_items);
    int sent;
    int seg_left;
    int grow_pct;
    int r;
    logic [2:0] k;
    sent = 0;
    seg_left = 0;
    grow_pct = 40;
    while (sent < n_items) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(120, 20);
        case ($urandom_range(2, 0))
          0: grow_pct = 65;
          1: grow_pct = 15;
          default: grow_pct = 40;
        endcase
      end
      r = $urandom_range(99, 0);
      if (r < grow_pct) begin
        k = K_APPEND;
      end else begin
        r = $urandom_range(99, 0);
        if (r < 15) k = K_POP_FRONT;
        else if (r < 30) k = K_POP_BACK;
        else if (r < 65) k = K_REMOVE_AT;
        else if (r < 95) k = K_READ_AT;
        else k = 3'($urandom_range(K_SPARE_7, K_SPARE_5));
      end
      send_request(k, pick_position(), rand_word());
      sent++;
      seg_left--;
    end
    wait_for_results();
  endtask

  task automatic test_output_stall();
    -> long_hold_req;
    repeat (30) begin
      case ($urandom_range(2, 0))
        0: send_request(K_READ_AT, pick_position(), rand_word());
        1: send_request(K_POP_BACK, pick_position(), rand_word());
        default: send_request(K_APPEND, pick_position(), rand_word());
      endcase
    end
    wait_for_results();
  endtask

  // receiver: ready pattern changes per segment, long hold on request
  always @(posedge clk) begin
    if (mode_left == 0) begin
      mode_left <= $urandom_range(500, 40);
      case ($urandom_range(3, 0))
        0: ready_mask <= 8'hFF;
        1: ready_mask <= 8'h01;
        default: ready_mask <= 8'($urandom) | 8'h10;
      endcase
    end else begin
      mode_left <= mode_left - 1;
    end
    mask_phase <= mask_phase + 3'd1;
    out_ready <= ready_mask[mask_phase] && !hold_active;
  end

  initial begin
    forever begin
      @(long_hold_req);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_results
    store_outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (awaited_outcomes.size() == 0) begin
        report_mismatch("unexpected result status", 64'(status), '0);
      end else begin
        want = awaited_outcomes.pop_front();
        if (status !== want.status) report_mismatch("status", 64'(status), 64'(want.status));
        if (read_value !== want.read_value) report_mismatch("read_value", read_value,
                                                            want.read_value);
        if (entry_count !== want.entry_count) report_mismatch("entry_count", 64'(entry_count),
                                                              64'(want.entry_count));
      end
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("*** FAILED ***");
    $finish;
  end

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_empty_store();
    test_single_entry();
    test_positions();
    test_full_store();
    test_random_mix(1100);
    test_output_stall();
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/isq_pkg.sv
design/indexed_sequence_store.sv
design/isq_port_checker.sv
test/tb_top.sv
